/* design/bmbb_pkg.sv */
// Package for the background mask and bounding box block.
// Holds the shared constants, the controller state type and the command, status, sample and result structs.
// No dependencies.
package bmbb_pkg;

    localparam int SAMPLES    = 10;
    localparam int MAX_DIM    = 4096;
    localparam int PIX_W      = 8;
    localparam int COORD_W    = 12;
    localparam int CNT_W      = $clog2(SAMPLES + 1);
    localparam int IDX_W      = (SAMPLES > 1) ? $clog2(SAMPLES) : 1;
    localparam int PROD_W     = PIX_W + CNT_W;
    localparam int SAMPLE_W   = PIX_W + 2 * COORD_W;
    localparam int RES_W      = PIX_W + 1 + 4 * COORD_W;
    localparam int OUT_DATA_W = ((RES_W + 7) / 8) * 8;
    localparam int PAD_W      = OUT_DATA_W - RES_W;

    localparam logic [PIX_W-1:0]   THR_RESET = PIX_W'(25);
    localparam logic [PIX_W-1:0]   MASK_FG   = PIX_W'(255);
    localparam logic [PIX_W-1:0]   MASK_BG   = '0;
    localparam logic [COORD_W-1:0] COORD_MAX = COORD_W'(MAX_DIM - 1);

    localparam logic KIND_MASK    = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_FL_RD,
        S_FL_EMIT,
        S_SUM
    } t_state;

    typedef struct packed {
        logic take;
        logic emit_flush;
        logic emit_sum;
        logic last;
    } t_cmd;

    typedef struct packed {
        logic full;
        logic fill_last;
        logic idx_last;
        logic out_free;
    } t_status;

    typedef struct packed {
        logic [COORD_W-1:0] y;
        logic [COORD_W-1:0] x;
        logic [PIX_W-1:0]   pix;
    } t_sample;

    typedef struct packed {
        logic               kind;
        logic [PIX_W-1:0]   mask;
        logic               found;
        logic [COORD_W-1:0] min_x;
        logic [COORD_W-1:0] min_y;
        logic [COORD_W-1:0] max_x;
        logic [COORD_W-1:0] max_y;
        logic               last;
    } t_result;

endpackage

/* design/bmbb_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module bmbb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                   i_clk,
    input  logic                   i_we,
    input  logic [ADDR_W-1:0]      i_waddr,
    input  logic [WIDTH-1:0]       i_wdata,
    input  logic [ADDR_W-1:0]      i_raddr,
    output logic [WIDTH-1:0]       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* design/bmbb_ctrl.sv */
// Controller state machine: input acceptance, sample flush sequencing and summary.
// Depends on bmbb_pkg.
module bmbb_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  logic             i_eof,
    input  bmbb_pkg::t_status i_st,
    output logic             o_ready,
    output bmbb_pkg::t_cmd    o_cmd
);

    bmbb_pkg::t_state r_state, n_state;
    logic             r_eof, n_eof;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= bmbb_pkg::S_IDLE;
            r_eof   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_eof   <= n_eof;
        end
    end

    always_comb begin
        n_state = r_state;
        n_eof   = r_eof;
        o_ready = 1'b0;
        o_cmd   = '0;
        unique case (r_state)
            bmbb_pkg::S_IDLE: begin
                o_ready = i_st.out_free;
                if (i_valid && i_st.out_free) begin
                    o_cmd.take = 1'b1;
                    o_cmd.last = !i_eof;
                    n_eof      = i_eof;
                    if (i_st.full) begin
                        n_state = i_eof ? bmbb_pkg::S_SUM : bmbb_pkg::S_IDLE;
                    end else if (i_st.fill_last || i_eof) begin
                        n_state = bmbb_pkg::S_FL_RD;
                    end
                end
            end
            bmbb_pkg::S_FL_RD: begin
                n_state = bmbb_pkg::S_FL_EMIT;
            end
            bmbb_pkg::S_FL_EMIT: begin
                if (i_st.out_free) begin
                    o_cmd.emit_flush = 1'b1;
                    o_cmd.last       = i_st.idx_last && !r_eof;
                    if (i_st.idx_last) begin
                        n_state = r_eof ? bmbb_pkg::S_SUM : bmbb_pkg::S_IDLE;
                    end else begin
                        n_state = bmbb_pkg::S_FL_RD;
                    end
                end
            end
            bmbb_pkg::S_SUM: begin
                if (i_st.out_free) begin
                    o_cmd.emit_sum = 1'b1;
                    o_cmd.last     = 1'b1;
                    n_state        = bmbb_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = bmbb_pkg::S_IDLE;
            end
        endcase
    end

endmodule

/* design/bmbb_datapath.sv */
// Datapath: sample buffer, background sum, classifier, coordinates, box and output register.
// Depends on bmbb_pkg and bmbb_ram.
module bmbb_datapath (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  bmbb_pkg::t_cmd                      i_cmd,
    output bmbb_pkg::t_status                   o_st,
    input  logic [bmbb_pkg::PIX_W-1:0]          i_pixel,
    input  logic                               i_eor,
    input  logic                               i_eof,
    input  logic                               i_cfg_we,
    input  logic [bmbb_pkg::PIX_W-1:0]          i_cfg_wdata,
    input  logic                               i_out_ready,
    output logic                               o_out_valid,
    output bmbb_pkg::t_result                   o_out
);

    logic [bmbb_pkg::PIX_W-1:0]   r_thr;
    logic [bmbb_pkg::CNT_W-1:0]   r_count;
    logic [bmbb_pkg::IDX_W-1:0]   r_idx;
    logic [bmbb_pkg::PROD_W-1:0]  r_sum;
    logic [bmbb_pkg::COORD_W-1:0] r_col, r_row;
    logic [bmbb_pkg::COORD_W-1:0] r_left, r_top, r_right, r_bottom;
    logic                         r_found;
    logic                         r_out_valid;
    bmbb_pkg::t_result            r_out, n_out;

    bmbb_pkg::t_sample            w_wr, w_rd, w_cls;
    logic [bmbb_pkg::PROD_W-1:0]  w_scaled, w_diff, w_thr_n;
    logic                         w_fg, w_full, w_buf_wr, w_load_mask, w_upd;

    assign w_full       = r_count == bmbb_pkg::CNT_W'(bmbb_pkg::SAMPLES);
    assign o_st.full      = w_full;
    assign o_st.fill_last = r_count == bmbb_pkg::CNT_W'(bmbb_pkg::SAMPLES - 1);
    assign o_st.idx_last  = bmbb_pkg::CNT_W'(r_idx) == r_count - bmbb_pkg::CNT_W'(1);
    assign o_st.out_free  = !r_out_valid || i_out_ready;

    assign w_buf_wr    = i_cmd.take && !w_full;
    assign w_load_mask = (i_cmd.take && w_full) || i_cmd.emit_flush;

    assign w_wr.pix = i_pixel;
    assign w_wr.x   = r_col;
    assign w_wr.y   = r_row;

    bmbb_ram #(
        .WIDTH (bmbb_pkg::SAMPLE_W),
        .DEPTH (bmbb_pkg::SAMPLES)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_buf_wr),
        .i_waddr (r_count[bmbb_pkg::IDX_W-1:0]),
        .i_wdata (w_wr),
        .i_raddr (r_idx),
        .o_rdata (w_rd)
    );

    // The pixel is tested as |n*pixel - sum| > threshold*n with n the samples seen.
    assign w_cls    = i_cmd.emit_flush ? w_rd : w_wr;
    assign w_scaled = {{bmbb_pkg::CNT_W{1'b0}}, w_cls.pix}
                    * {{bmbb_pkg::PIX_W{1'b0}}, r_count};
    assign w_thr_n  = {{bmbb_pkg::CNT_W{1'b0}}, r_thr}
                    * {{bmbb_pkg::PIX_W{1'b0}}, r_count};
    assign w_diff   = (w_scaled > r_sum) ? (w_scaled - r_sum) : (r_sum - w_scaled);
    assign w_fg     = w_diff > w_thr_n;
    assign w_upd    = w_load_mask && w_fg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr <= bmbb_pkg::THR_RESET;
        end else if (i_cfg_we) begin
            r_thr <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.emit_sum) begin
            r_count  <= '0;
            r_idx    <= '0;
            r_sum    <= '0;
            r_col    <= '0;
            r_row    <= '0;
            r_left   <= bmbb_pkg::COORD_MAX;
            r_top    <= bmbb_pkg::COORD_MAX;
            r_right  <= '0;
            r_bottom <= '0;
            r_found  <= 1'b0;
        end else begin
            if (w_buf_wr) begin
                r_count <= r_count + bmbb_pkg::CNT_W'(1);
                r_sum   <= r_sum + bmbb_pkg::PROD_W'(i_pixel);
            end
            if (i_cmd.emit_flush) begin
                r_idx <= o_st.idx_last ? '0 : r_idx + bmbb_pkg::IDX_W'(1);
            end
            if (i_cmd.take && !i_eof) begin
                if (i_eor) begin
                    r_col <= '0;
                    if (r_row != bmbb_pkg::COORD_MAX) begin
                        r_row <= r_row + bmbb_pkg::COORD_W'(1);
                    end
                end else if (r_col != bmbb_pkg::COORD_MAX) begin
                    r_col <= r_col + bmbb_pkg::COORD_W'(1);
                end
            end
            if (w_upd) begin
                r_found <= 1'b1;
                if (w_cls.x < r_left) begin
                    r_left <= w_cls.x;
                end
                if (w_cls.y < r_top) begin
                    r_top <= w_cls.y;
                end
                if (w_cls.x > r_right) begin
                    r_right <= w_cls.x;
                end
                if (w_cls.y > r_bottom) begin
                    r_bottom <= w_cls.y;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load_mask || i_cmd.emit_sum) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_comb begin
        n_out = r_out;
        if (w_load_mask) begin
            n_out       = '0;
            n_out.kind  = bmbb_pkg::KIND_MASK;
            n_out.mask  = w_fg ? bmbb_pkg::MASK_FG : bmbb_pkg::MASK_BG;
            n_out.last  = i_cmd.last;
        end else if (i_cmd.emit_sum) begin
            n_out       = '0;
            n_out.kind  = bmbb_pkg::KIND_SUMMARY;
            n_out.found = r_found;
            n_out.last  = 1'b1;
            if (r_found) begin
                n_out.min_x = r_left;
                n_out.min_y = r_top;
                n_out.max_x = r_right;
                n_out.max_y = r_bottom;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

/* design/background_mask_bounding_box.sv */
// Top level of the background mask and bounding box block.
// Depends on bmbb_pkg, bmbb_ctrl and bmbb_datapath.
//
// Each frame's first SAMPLES pixels are buffered and give no result until the
// buffer fills or the frame ends; they then leave as mask results, read one at
// a time from the sample RAM through states S_FL_RD and S_FL_EMIT. Later pixels
// give their mask at once, so a steady stream runs at one pixel per clock while
// the output is taken. The last pixel of a frame adds one summary result
// with the bounding box after its masks. The threshold should be written only
// while the block is idle.
module background_mask_bounding_box (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,   // pixel
    input  logic        i_s_axis_tuser,   // end_of_row
    input  logic        i_s_axis_tlast,   // end_of_frame
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // mask_value, found, min_x, min_y, max_x, max_y, zero padding
    output logic [bmbb_pkg::OUT_DATA_W-1:0] o_m_axis_tdata,
    output logic        o_m_axis_tuser,   // result_kind
    output logic        o_m_axis_tlast,   // last
    input  logic        i_cfg_we,
    input  logic [7:0]  i_cfg_wdata       // threshold
);

    bmbb_pkg::t_cmd    w_cmd;
    bmbb_pkg::t_status w_st;
    bmbb_pkg::t_result w_out;

    bmbb_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_axis_tvalid),
        .i_eof   (i_s_axis_tlast),
        .i_st    (w_st),
        .o_ready (o_s_axis_tready),
        .o_cmd   (w_cmd)
    );

    bmbb_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_st        (w_st),
        .i_pixel     (i_s_axis_tdata),
        .i_eor       (i_s_axis_tuser),
        .i_eof       (i_s_axis_tlast),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_out_ready (i_m_axis_tready),
        .o_out_valid (o_m_axis_tvalid),
        .o_out       (w_out)
    );

    assign o_m_axis_tdata = {{bmbb_pkg::PAD_W{1'b0}}, w_out.max_y, w_out.max_x,
                             w_out.min_y, w_out.min_x, w_out.found, w_out.mask};
    assign o_m_axis_tuser = w_out.kind;
    assign o_m_axis_tlast = w_out.last;

endmodule

/* tb/testbench.sv */
`timescale 1ns / 100ps
// Self-checking testbench for background_mask_bounding_box: streams gray pixel frames,
// predicts every mask and frame summary result in step, and compares them as they leave.
// Depends on bmbb_pkg and the background_mask_bounding_box RTL.
module testbench;

    localparam int DRAIN_CYCLES   = 32;
    localparam int RX_HOLD_CYCLES = 400;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int MAX_REPORTS    = 10;

    typedef struct packed {
        logic [bmbb_pkg::PIX_W-1:0] pix;
        logic                       eor;
        logic                       eof;
    } t_pixel_req;

    logic                            i_clk = 1'b0;
    logic                            i_rst_n = 1'b0;
    logic                            i_s_axis_tvalid = 1'b0;
    logic                            o_s_axis_tready;
    logic [7:0]                      i_s_axis_tdata = '0;
    logic                            i_s_axis_tuser = 1'b0;
    logic                            i_s_axis_tlast = 1'b0;
    logic                            o_m_axis_tvalid;
    logic                            i_m_axis_tready = 1'b0;
    logic [bmbb_pkg::OUT_DATA_W-1:0] o_m_axis_tdata;
    logic                            o_m_axis_tuser;
    logic                            o_m_axis_tlast;
    logic                            i_cfg_we = 1'b0;
    logic [7:0]                      i_cfg_wdata = '0;

    background_mask_bounding_box dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .i_s_axis_tlast  (i_s_axis_tlast),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .o_m_axis_tlast  (o_m_axis_tlast),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    t_pixel_req        pixel_q[$];
    bmbb_pkg::t_result mask_box_q[$];
    int                mismatch_count = 0;
    int                tx_gap_pct = 0;
    int                rx_stall_pct = 0;
    int                rx_hold_reqs = 0;

    // Predictor state for the current frame.
    int thr_model = int'(bmbb_pkg::THR_RESET);
    int bg_pix[bmbb_pkg::SAMPLES];
    int bg_x[bmbb_pkg::SAMPLES];
    int bg_y[bmbb_pkg::SAMPLES];
    int bg_sum;
    int bg_count;
    int col_pos;
    int row_pos;
    int box_x0;
    int box_y0;
    int box_x1;
    int box_y1;
    bit fg_seen;

    function automatic void clear_frame();
        bg_sum   = 0;
        bg_count = 0;
        col_pos  = 0;
        row_pos  = 0;
        box_x0   = int'(bmbb_pkg::COORD_MAX);
        box_y0   = int'(bmbb_pkg::COORD_MAX);
        box_x1   = 0;
        box_y1   = 0;
        fg_seen  = 1'b0;
    endfunction

    function automatic bmbb_pkg::t_result make_result(logic kind,
                                                      logic [bmbb_pkg::PIX_W-1:0] mask,
                                                      logic found, int x0, int y0,
                                                      int x1, int y1, logic last);
        bmbb_pkg::t_result r;
        r.kind  = kind;
        r.mask  = mask;
        r.found = found;
        r.min_x = x0[bmbb_pkg::COORD_W-1:0];
        r.min_y = y0[bmbb_pkg::COORD_W-1:0];
        r.max_x = x1[bmbb_pkg::COORD_W-1:0];
        r.max_y = y1[bmbb_pkg::COORD_W-1:0];
        r.last  = last;
        return r;
    endfunction

    function automatic logic [bmbb_pkg::PIX_W-1:0] classify_pixel(int pix, int x, int y,
                                                                  int n);
        int diff;
        diff = n * pix - bg_sum;
        if (diff < 0) diff = -diff;
        if (diff > thr_model * n) begin
            if (x < box_x0) box_x0 = x;
            if (y < box_y0) box_y0 = y;
            if (x > box_x1) box_x1 = x;
            if (y > box_y1) box_y1 = y;
            fg_seen = 1'b1;
            return bmbb_pkg::MASK_FG;
        end
        return bmbb_pkg::MASK_BG;
    endfunction

    function automatic void segment_pixel(t_pixel_req req);
        logic [bmbb_pkg::PIX_W-1:0] m;
        if (bg_count < bmbb_pkg::SAMPLES) begin
            bg_pix[bg_count] = int'(req.pix);
            bg_x[bg_count]   = col_pos;
            bg_y[bg_count]   = row_pos;
            bg_sum += int'(req.pix);
            bg_count++;
            if (bg_count == bmbb_pkg::SAMPLES || req.eof) begin
                for (int k = 0; k < bg_count; k++) begin
                    m = classify_pixel(bg_pix[k], bg_x[k], bg_y[k], bg_count);
                    mask_box_q.push_back(make_result(bmbb_pkg::KIND_MASK, m, 1'b0,
                                                     0, 0, 0, 0,
                                                     k == bg_count - 1 && !req.eof));
                end
            end
        end else begin
            m = classify_pixel(int'(req.pix), col_pos, row_pos, bmbb_pkg::SAMPLES);
            mask_box_q.push_back(make_result(bmbb_pkg::KIND_MASK, m, 1'b0, 0, 0, 0, 0,
                                             !req.eof));
        end
        if (req.eof) begin
            if (fg_seen)
                mask_box_q.push_back(make_result(bmbb_pkg::KIND_SUMMARY, bmbb_pkg::MASK_BG,
                                                 1'b1, box_x0, box_y0, box_x1, box_y1,
                                                 1'b1));
            else
                mask_box_q.push_back(make_result(bmbb_pkg::KIND_SUMMARY, bmbb_pkg::MASK_BG,
                                                 1'b0, 0, 0, 0, 0, 1'b1));
            clear_frame();
        end else if (req.eor) begin
            col_pos = 0;
            if (row_pos < int'(bmbb_pkg::COORD_MAX)) row_pos++;
        end else if (col_pos < int'(bmbb_pkg::COORD_MAX)) begin
            col_pos++;
        end
    endfunction

    function automatic int idle_len();
        if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Request driver.
    t_pixel_req cur_req = '0;
    bit         offering = 1'b0;
    int         gap_left = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            offering = 1'b0;
            gap_left = 0;
        end else begin
            if (i_s_axis_tvalid && o_s_axis_tready) begin
                segment_pixel(cur_req);
                offering = 1'b0;
                gap_left = ($urandom_range(0, 99) < tx_gap_pct) ? idle_len() : 0;
            end
            if (!offering) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else if (pixel_q.size() != 0) begin
                    cur_req  = pixel_q.pop_front();
                    offering = 1'b1;
                end
            end
        end
        i_s_axis_tvalid <= offering;
        i_s_axis_tdata  <= cur_req.pix;
        i_s_axis_tuser  <= cur_req.eor;
        i_s_axis_tlast  <= cur_req.eof;
    end

    // Result monitor and receiver back-pressure.
    int rx_hold_done = 0;
    int stall_left = 0;

    always @(posedge i_clk) begin : result_monitor
        bmbb_pkg::t_result got;
        bmbb_pkg::t_result want;
        if (!i_rst_n) begin
            stall_left = 0;
            i_m_axis_tready <= 1'b0;
        end else begin
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                got.kind  = o_m_axis_tuser;
                got.mask  = o_m_axis_tdata[bmbb_pkg::PIX_W-1:0];
                got.found = o_m_axis_tdata[bmbb_pkg::PIX_W];
                got.min_x = o_m_axis_tdata[bmbb_pkg::PIX_W + 1 +: bmbb_pkg::COORD_W];
                got.min_y = o_m_axis_tdata[bmbb_pkg::PIX_W + 1 + bmbb_pkg::COORD_W
                                           +: bmbb_pkg::COORD_W];
                got.max_x = o_m_axis_tdata[bmbb_pkg::PIX_W + 1 + 2 * bmbb_pkg::COORD_W
                                           +: bmbb_pkg::COORD_W];
                got.max_y = o_m_axis_tdata[bmbb_pkg::PIX_W + 1 + 3 * bmbb_pkg::COORD_W
                                           +: bmbb_pkg::COORD_W];
                got.last  = o_m_axis_tlast;
                if (mask_box_q.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                        $display("%0t: unexpected result kind=%0d mask=%0d", $realtime,
                                 got.kind, got.mask);
                end else begin
                    want = mask_box_q.pop_front();
                    if (got.kind !== want.kind || got.mask !== want.mask
                        || got.found !== want.found || got.min_x !== want.min_x
                        || got.min_y !== want.min_y || got.max_x !== want.max_x
                        || got.max_y !== want.max_y || got.last !== want.last) begin
                        mismatch_count++;
                        if (mismatch_count <= MAX_REPORTS)
                            $display({"%0t: result mismatch kind %0d/%0d mask %0d/%0d ",
                                      "found %0d/%0d box (%0d,%0d)-(%0d,%0d) / ",
                                      "(%0d,%0d)-(%0d,%0d) last %0d/%0d (expected/actual)"},
                                     $realtime, want.kind, got.kind, want.mask, got.mask,
                                     want.found, got.found, want.min_x, want.min_y,
                                     want.max_x, want.max_y, got.min_x, got.min_y,
                                     got.max_x, got.max_y, want.last, got.last);
                    end
                end
            end
            if (rx_hold_done != rx_hold_reqs) begin
                rx_hold_done = rx_hold_reqs;
                stall_left   = RX_HOLD_CYCLES;
            end else if (stall_left == 0 && $urandom_range(0, 99) < rx_stall_pct) begin
                stall_left = idle_len();
            end
            if (stall_left > 0) begin
                stall_left--;
                i_m_axis_tready <= 1'b0;
            end else begin
                i_m_axis_tready <= 1'b1;
            end
        end
    end

    int quiet_cycles = 0;

    always @(posedge i_clk) begin
        if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    task automatic push_pixel(int pix, bit eor, bit eof);
        t_pixel_req r;
        r.pix = pix[bmbb_pkg::PIX_W-1:0];
        r.eor = eor;
        r.eof = eof;
        pixel_q.push_back(r);
    endtask

    // One frame: mostly a noisy flat background with foreground specks, some wild pixels.
    task automatic queue_random_frame();
        int len;
        int width;
        int base;
        int v;
        int r;
        bit eor;
        r = $urandom_range(0, 9);
        if (r < 2) len = $urandom_range(1, bmbb_pkg::SAMPLES - 1);
        else if (r == 2) len = bmbb_pkg::SAMPLES;
        else len = $urandom_range(bmbb_pkg::SAMPLES + 1, 60);
        width = $urandom_range(1, 12);
        base  = $urandom_range(0, 255);
        for (int i = 0; i < len; i++) begin
            r = $urandom_range(0, 99);
            if (r < 10) v = $urandom_range(0, 255);
            else if (r < 25) v = (base < 128) ? base + $urandom_range(30, 127)
                                              : base - $urandom_range(30, 127);
            else v = base + $urandom_range(0, 16) - 8;
            if (v < 0) v = 0;
            if (v > 255) v = 255;
            eor = ((i + 1) % width == 0);
            if ($urandom_range(0, 9) == 0) eor = !eor;
            push_pixel(v, eor, i == len - 1);
        end
    endtask

    task automatic set_phase(int thr, int tx_pct, int rx_pct);
        if (thr >= 0) begin
            @(posedge i_clk);
            i_cfg_we    <= 1'b1;
            i_cfg_wdata <= 8'(thr);
            @(posedge i_clk);
            i_cfg_we  <= 1'b0;
            thr_model = thr;
        end
        tx_gap_pct   = tx_pct;
        rx_stall_pct = rx_pct;
        @(negedge i_clk);
    endtask

    task automatic drain();
        while (pixel_q.size() != 0 || i_s_axis_tvalid || mask_box_q.size() != 0)
            @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    int phase_thr[6];
    int phase_tx[6];
    int phase_rx[6];
    int phase_len[6];

    initial begin
        clear_frame();
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset threshold: exact threshold boundary, single pixel frame, short frame,
        // and a frame that ends on the pixel that fills the background buffer.
        set_phase(-1, 20, 20);
        for (int i = 0; i < bmbb_pkg::SAMPLES; i++) push_pixel(0, i == 4, 1'b0);
        push_pixel(255, 1'b0, 1'b0);
        push_pixel(26, 1'b0, 1'b0);
        push_pixel(25, 1'b1, 1'b1);
        push_pixel(255, 1'b0, 1'b1);
        push_pixel(0, 1'b0, 1'b0);
        push_pixel(255, 1'b1, 1'b0);
        push_pixel(0, 1'b0, 1'b1);
        for (int i = 0; i < bmbb_pkg::SAMPLES; i++)
            push_pixel((i % 2) ? 255 : 0, 1'b0, i == bmbb_pkg::SAMPLES - 1);
        drain();

        phase_thr = '{0, 255, $urandom_range(1, 254), $urandom_range(1, 254),
                      $urandom_range(1, 254), 25};
        phase_tx  = '{30, 10, 0, 50, 20, 5};
        phase_rx  = '{30, 50, 0, 10, 20, 5};
        phase_len = '{40, 40, 50, 40, 50, 40};
        for (int p = 0; p < 6; p++) begin
            set_phase(phase_thr[p], phase_tx[p], phase_rx[p]);
            // The receiver holds off while the sender keeps offering a full phase.
            if (p == 2) rx_hold_reqs++;
            while (pixel_q.size() < phase_len[p]) queue_random_frame();
            drain();
        end

        if (mismatch_count == 0 && mask_box_q.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

/* sim.f */
design/bmbb_pkg.sv
design/bmbb_ram.sv
design/bmbb_ctrl.sv
design/bmbb_datapath.sv
design/background_mask_bounding_box.sv
tb/testbench.sv
